// File: hdl/jms_pkg.sv
package jms_pkg;

  localparam logic [6:0] MAX_BITS         = 7'd64;
  localparam logic [6:0] RESET_TMS_PULSES = 7'd5;
  localparam logic [3:0] TMS_ENTER_IR     = 4'b0011;
  localparam logic [3:0] TMS_ENTER_DR     = 4'b0001;
  localparam logic [6:0] ENTER_STEPS_IR   = 7'd4;
  localparam logic [6:0] ENTER_STEPS_DR   = 7'd3;

  typedef enum logic [1:0] {
    REQ_RESET   = 2'd0,
    REQ_SCAN_IR = 2'd1,
    REQ_SCAN_DR = 2'd2,
    REQ_TICK    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_TMSRST = 2'd0,
    KIND_IR     = 2'd1,
    KIND_DR     = 2'd2,
    KIND_TRST   = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_RSTHI = 6'b000010,
    PH_RSTLO = 6'b000100,
    PH_ENTER = 6'b001000,
    PH_SHIFT = 6'b010000,
    PH_EXIT  = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [6:0]  pulse_count;
    kind_t       scan_kind;
    logic [6:0]  length;
    logic [63:0] out_shift;
    logic [63:0] capture;
  } jms_state_t;

  typedef struct packed {
    logic        accepted;
    logic        tck_pulse;
    logic        tms;
    logic        tdi;
    logic        trst;
    logic        busy_res;
    logic        done_res;
    logic [63:0] captured_data;
  } jms_result_t;

endpackage

// File: hdl/jms_step.sv
module jms_step (
  input  jms_pkg::jms_state_t  cur,
  input  logic                 use_trst,
  input  logic [1:0]           req_type,
  input  logic [6:0]           bit_count,
  input  logic [63:0]          shift_out_data,
  input  logic                 tdo_sample,
  output jms_pkg::jms_state_t  nxt,
  output jms_pkg::jms_result_t res
);
  import jms_pkg::*;

  logic [6:0] pc_inc;

  assign pc_inc = cur.pulse_count + 7'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    if (req_type != REQ_TICK) begin
      if (cur.phase == PH_IDLE) begin
        if (req_type == REQ_RESET) begin
          res.accepted    = 1'b1;
          nxt.phase       = PH_RSTHI;
          nxt.pulse_count = '0;
          nxt.scan_kind   = use_trst ? KIND_TRST : KIND_TMSRST;
        end else if (bit_count inside {[7'd1:MAX_BITS]}) begin
          res.accepted    = 1'b1;
          nxt.phase       = PH_ENTER;
          nxt.pulse_count = '0;
          nxt.scan_kind   = (req_type == REQ_SCAN_IR) ? KIND_IR : KIND_DR;
          nxt.length      = bit_count;
          nxt.out_shift   = shift_out_data;
          nxt.capture     = '0;
        end
      end
    end else if (cur.phase != PH_IDLE) begin
      res.tck_pulse = 1'b1;
      case (cur.phase)
        PH_RSTHI: begin
          if (cur.scan_kind == KIND_TRST) begin
            res.trst  = 1'b1;
            nxt.phase = PH_RSTLO;
          end else begin
            res.tms         = 1'b1;
            nxt.pulse_count = pc_inc;
            if (pc_inc >= RESET_TMS_PULSES) begin
              nxt.phase = PH_RSTLO;
            end
          end
        end
        PH_RSTLO: begin
          res.done_res    = 1'b1;
          nxt.phase       = PH_IDLE;
          nxt.pulse_count = '0;
        end
        PH_ENTER: begin
          if (cur.scan_kind == KIND_IR) begin
            res.tms = TMS_ENTER_IR[cur.pulse_count[1:0]];
          end else begin
            res.tms = TMS_ENTER_DR[cur.pulse_count[1:0]];
          end
          nxt.pulse_count = pc_inc;
          if (pc_inc >= ((cur.scan_kind == KIND_IR) ? ENTER_STEPS_IR : ENTER_STEPS_DR)) begin
            nxt.phase       = PH_SHIFT;
            nxt.pulse_count = '0;
          end
        end
        PH_SHIFT: begin
          res.tdi         = cur.out_shift[0];
          nxt.out_shift   = {1'b0, cur.out_shift[63:1]};
          res.tms         = (pc_inc >= cur.length);
          nxt.capture     = cur.capture | (64'(tdo_sample) << cur.pulse_count[5:0]);
          nxt.pulse_count = pc_inc;
          if (pc_inc >= cur.length) begin
            nxt.phase       = PH_EXIT;
            nxt.pulse_count = '0;
          end
        end
        PH_EXIT: begin
          if (cur.pulse_count == 7'd0) begin
            res.tms         = 1'b1;
            nxt.pulse_count = 7'd1;
          end else begin
            res.done_res    = 1'b1;
            nxt.phase       = PH_IDLE;
            nxt.pulse_count = '0;
          end
        end
        default: begin
          res.tck_pulse   = 1'b0;
          nxt.phase       = PH_IDLE;
          nxt.pulse_count = '0;
        end
      endcase
    end
    res.busy_res      = (nxt.phase != PH_IDLE);
    res.captured_data = nxt.capture;
  end

endmodule

// File: hdl/jms_out_reg.sv
module jms_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  jms_pkg::jms_result_t res_in,
  input  logic                 out_stall,
  output logic                 out_valid,
  output jms_pkg::jms_result_t res_out
);
  import jms_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  jms_result_t res_r;

  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// File: hdl/jtag_master_ir_dr_scan.sv
// A result is registered in the output register and appears in the cycle after its item is transferred.
// Throughput: one item per cycle while in_stall is low; the TAP sequencer state advances on every transfer.
// The input side stalls only while a result waits in the output register and is stalled.
// Reset (rst_n low, synchronous) returns the sequencer to Idle, clears all counters,
// the shift and capture registers, use_trst and the output valid flag.
module jtag_master_ir_dr_scan (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_bit_count,
  input  logic [63:0] in_shift_out_data,
  input  logic        in_tdo_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic        out_tck_pulse,
  output logic        out_tms,
  output logic        out_tdi,
  output logic        out_trst,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [63:0] out_captured_data
);
  import jms_pkg::*;

  logic        use_trst_r;
  jms_state_t  state_r;
  jms_state_t  state_nxt;
  jms_result_t step_res;
  jms_result_t out_res;
  logic        xfer;

  assign in_stall = out_valid & out_stall;
  assign xfer     = in_valid & ~in_stall;

  jms_step u_step (
    .cur            (state_r),
    .use_trst       (use_trst_r),
    .req_type       (in_req_type),
    .bit_count      (in_bit_count),
    .shift_out_data (in_shift_out_data),
    .tdo_sample     (in_tdo_sample),
    .nxt            (state_nxt),
    .res            (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_trst_r <= 1'b0;
    end else if (cfg_wr_en) begin
      use_trst_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_IDLE;
      state_r.pulse_count <= '0;
      state_r.scan_kind   <= KIND_TMSRST;
      state_r.length      <= '0;
      state_r.out_shift   <= '0;
      state_r.capture     <= '0;
    end else if (xfer) begin
      state_r <= state_nxt;
    end
  end

  jms_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (xfer),
    .res_in    (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_accepted      = out_res.accepted;
  assign out_tck_pulse     = out_res.tck_pulse;
  assign out_tms           = out_res.tms;
  assign out_tdi           = out_res.tdi;
  assign out_trst          = out_res.trst;
  assign out_busy_res      = out_res.busy_res;
  assign out_done_res      = out_res.done_res;
  assign out_captured_data = out_res.captured_data;

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> out_valid)
    else $error("transfer did not produce a result");

  a_busy_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && in_req_type != REQ_TICK && state_r.phase != PH_IDLE) |=> !out_accepted)
    else $error("command accepted while busy");

  a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_busy_res == (state_r.phase != PH_IDLE)))
    else $error("busy flag disagrees with sequencer state");

  a_done_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (state_r.phase == PH_IDLE && out_tck_pulse))
    else $error("done reported outside a final pulse");

endmodule
